/* src/stc_pkg.sv */
// Package for the separable triangle smoothing core.
// Holds shared constants, register codes, transaction structs and filter arithmetic.
// No dependencies.
package stc_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 9;
  localparam int ENT_W     = 2 * PIX_W;  // line memory entry: {newer, older}
  localparam int OUT_W     = 24;         // smoothed, row, col
  localparam int RES_DEPTH = 4;          // result queue depth, power of two

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_idx_e;

  // one finished horizontal value on its way to the vertical stage
  typedef struct packed {
    logic [PIX_W-1:0] h;         // horizontal result
    logic [7:0]       row;       // low bits of its row
    logic             up_ok;     // row >= 1: the row above can be finished
    logic             row_one;   // row == 1: row above is the top edge
    logic             last_row;  // also finish this row
    logic             eor;       // last value caused by its pixel
    logic             eof;       // last value of the frame
  } hev_t;

  // one result
  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic [7:0]       row;
    logic [7:0]       col;
    logic             eor;
    logic             eof;
  } res_t;

  // up to two results written to the result queue in one cycle
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_push_t;

  // (128*a + 768*b + 128*c) >> 10
  function automatic logic [PIX_W-1:0] tri3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                            logic [PIX_W-1:0] c);
    logic [17:0] s;
    s = {3'b0, a, 7'b0} + {1'b0, b, 9'b0} + {2'b0, b, 8'b0} + {3'b0, c, 7'b0};
    return s[17:10];
  endfunction

  // edge rule: (768*center + 256*nb) >> 10
  function automatic logic [PIX_W-1:0] tri2(logic [PIX_W-1:0] center,
                                            logic [PIX_W-1:0] nb);
    logic [17:0] s;
    s = {1'b0, center, 9'b0} + {2'b0, center, 8'b0} + {2'b0, nb, 8'b0};
    return s[17:10];
  endfunction

endpackage

/* src/stc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while no read is enabled. No dependencies.
module stc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/stc_hpass.sv */
// Horizontal pass: raster position, previous pixels and horizontal 3-tap filter.
// Issues one finished horizontal value per cycle while the vertical pass has a free slot;
// the last column's value is held in a register and issued in the next free slot. Depends on stc_pkg.
module stc_hpass import stc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] map_width_i,
  input  logic [CFG_W-1:0] map_height_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             slot_free_i,
  output logic             iss_valid_o,
  output logic [CW-1:0]    iss_col_o,
  output hev_t             iss_ev_o
);

  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CMW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CMH = (HW > CFG_W) ? HW : CFG_W;

  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [PIX_W-1:0] prev_q, prev2_q;
  logic             df_valid_q, df_valid_d;
  hev_t             df_q;
  logic [CW-1:0]    df_col_q;

  logic [CMW-1:0] w_ext;
  logic [CMH-1:0] h_ext;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [CW-1:0]  c;
  logic [RW-1:0]  r;
  logic           last_col, last_row, accept;
  hev_t           ev_a, ev_b;

  // effective size: out-of-range values clamp to 2 or the maximum
  always_comb begin
    w_ext = CMW'(map_width_i);
    h_ext = CMH'(map_height_i);
    if (w_ext < CMW'(2)) begin
      w_eff = WW'(2);
    end else if (w_ext > CMW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_ext);
    end
    if (h_ext < CMH'(2)) begin
      h_eff = HW'(2);
    end else if (h_ext > CMH'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_ext);
    end
  end

  // position clamped to the current size
  always_comb begin
    c = (WW'(col_q) >= w_eff) ? CW'(w_eff - WW'(1)) : col_q;
    r = (HW'(row_q) >= h_eff) ? RW'(h_eff - HW'(1)) : row_q;
    last_col = (WW'(c) == w_eff - WW'(1));
    last_row = (HW'(r) == h_eff - HW'(1));
  end

  // horizontal values: left neighbor column finished now, last column deferred
  always_comb begin
    ev_a.h        = (c == CW'(1)) ? tri2(prev_q, pixel_i) : tri3(prev2_q, prev_q, pixel_i);
    ev_a.row      = 8'(r);
    ev_a.up_ok    = (r != '0);
    ev_a.row_one  = (r == RW'(1));
    ev_a.last_row = last_row;
    ev_a.eor      = !last_col;
    ev_a.eof      = 1'b0;
    ev_b          = ev_a;
    ev_b.h        = tri2(pixel_i, prev_q);
    ev_b.eor      = 1'b1;
    ev_b.eof      = last_row;
  end

  assign in_ready_o = slot_free_i;
  assign accept     = in_valid_i && in_ready_o;

  // issue: a deferred value goes first; it only pends while column 0 is next
  always_comb begin
    iss_valid_o = accept && (c != '0);
    iss_col_o   = c - CW'(1);
    iss_ev_o    = ev_a;
    if (df_valid_q) begin
      iss_valid_o = slot_free_i;
      iss_col_o   = df_col_q;
      iss_ev_o    = df_q;
    end
  end

  // next position
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    df_valid_d = (accept && last_col) || (df_valid_q && !slot_free_i);
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : r + RW'(1);
      end else begin
        col_d = c + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      prev_q     <= '0;
      prev2_q    <= '0;
      df_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      df_valid_q <= df_valid_d;
      if (accept) begin
        prev2_q <= prev_q;
        prev_q  <= pixel_i;
      end
    end
  end

  // deferred last-column value
  always_ff @(posedge clk_i) begin
    if (accept && last_col) begin
      df_q     <= ev_b;
      df_col_q <= c;
    end
  end

endmodule

/* src/stc_vpass.sv */
// Vertical pass: line memory of the two previous horizontal rows, read-modify-write
// per horizontal value, vertical 3-tap filter. Depends on stc_pkg and stc_ram.
module stc_vpass import stc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          iss_valid_i,
  input  logic [CW-1:0] iss_col_i,
  input  hev_t          iss_ev_i,
  input  logic          space_ok_i,
  output logic          slot_free_o,
  output res_push_t     push_o
);

  logic             ev_valid_q;
  hev_t             ev_q;
  logic [CW-1:0]    ev_col_q;
  logic             fwd_q;
  logic [ENT_W-1:0] fwd_data_q;

  logic             ev_fire;
  logic [ENT_W-1:0] rdata, ent, wdata;
  logic [PIX_W-1:0] older, newer;
  logic             has_own;
  logic [7:0]       col8;

  assign ev_fire     = ev_valid_q && space_ok_i;
  assign slot_free_o = !ev_valid_q || space_ok_i;

  // line memory entry: newer row in the high byte, older row in the low byte
  stc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ev_fire),
    .waddr_i (ev_col_q),
    .wdata_i (wdata),
    .re_i    (iss_valid_i),
    .raddr_i (iss_col_i),
    .rdata_o (rdata)
  );

  // forward a write that lands in the same cycle as a read of that column
  assign ent   = fwd_q ? fwd_data_q : rdata;
  assign older = ent[PIX_W-1:0];
  assign newer = ent[ENT_W-1:PIX_W];
  assign wdata = {ev_q.h, newer};

  // vertical filter: row above first, then the last row's own value
  always_comb begin
    has_own        = ev_q.last_row && ev_q.up_ok;
    col8           = 8'(ev_col_q);
    push_o.v0      = ev_fire && ev_q.up_ok;
    push_o.v1      = ev_fire && has_own;
    push_o.r0.smoothed = ev_q.row_one ? tri2(newer, ev_q.h) : tri3(older, newer, ev_q.h);
    push_o.r0.row  = ev_q.row - 8'd1;
    push_o.r0.col  = col8;
    push_o.r0.eor  = ev_q.eor && !has_own;
    push_o.r0.eof  = ev_q.eof && !has_own;
    push_o.r1.smoothed = tri2(ev_q.h, newer);
    push_o.r1.row  = ev_q.row;
    push_o.r1.col  = col8;
    push_o.r1.eor  = ev_q.eor;
    push_o.r1.eof  = ev_q.eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (iss_valid_i) begin
        ev_valid_q <= 1'b1;
        fwd_q      <= ev_fire && (iss_col_i == ev_col_q);
      end else if (ev_fire) begin
        ev_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_valid_i) begin
      ev_q       <= iss_ev_i;
      ev_col_q   <= iss_col_i;
      fwd_data_q <= wdata;
    end
  end

endmodule

/* src/stc_rfifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Head entry is a register and holds while stalled. Depends on stc_pkg.
module stc_rfifo import stc_pkg::*; #(
  parameter int DEPTH = RES_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      space_ok_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_t      out_data_o
);

  localparam int AW = $clog2(DEPTH);

  res_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          pop;
  logic [1:0]    n_push;

  assign pop         = out_valid_o && out_ready_i;
  assign n_push      = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign space_ok_o  = (cnt_q <= (AW + 1)'(DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + AW'(n_push);
      rd_q  <= rd_q + AW'(pop);
      cnt_q <= cnt_q + (AW + 1)'(n_push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_q + AW'(1)] <= push_i.r1;
    end
  end

endmodule

/* src/separable_triangle_smoothing_core.sv */
// Separable 3-tap triangle smoothing of an 8-bit map in raster order.
// Throughput: one pixel per cycle while the output is ready; on the last row each horizontal
// value yields two results and the one-per-cycle output port then holds back the input.
// Path: a pixel's value is registered in the vertical stage, then in the result queue; the last
// column's second value first waits in a deferral register for the next free issue slot.
// Reset: position, previous pixels and queues clear, sizes return to 2; line memory
// is not cleared.
module separable_triangle_smoothing_core import stc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input pixels
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] pixel
  // results
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // [7:0] smoothed, [15:8] out_row, [23:16] out_col
  output logic             m_axis_tlast,   // end_of_run
  output logic [0:0]       m_axis_tuser,   // [0] end_of_frame
  // configuration writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0] map_width_q, map_height_q;
  logic             slot_free, iss_valid, space_ok;
  logic [CW-1:0]    iss_col;
  hev_t             iss_ev;
  res_push_t        push;
  res_t             res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= CFG_W'(2);
      map_height_q <= CFG_W'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i;
      endcase
    end
  end

  stc_hpass #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hpass (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .pixel_i      (s_axis_tdata),
    .slot_free_i  (slot_free),
    .iss_valid_o  (iss_valid),
    .iss_col_o    (iss_col),
    .iss_ev_o     (iss_ev)
  );

  stc_vpass #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_vpass (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_valid_i (iss_valid),
    .iss_col_i   (iss_col),
    .iss_ev_i    (iss_ev),
    .space_ok_i  (space_ok),
    .slot_free_o (slot_free),
    .push_o      (push)
  );

  stc_rfifo u_rfifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {res.col, res.row, res.smoothed};
  assign m_axis_tlast = res.eor;
  assign m_axis_tuser = res.eof;

endmodule

/* src/stc_checker.sv */
// Port-level checks for the smoothing core, attached to the top level by bind.
// Depends on stc_pkg and separable_triangle_smoothing_core.
module stc_checker import stc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast,
  input logic [0:0]       m_axis_tuser
);

  // set once any pixel transaction has happened since reset
  logic seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      seen_q <= 1'b1;
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // frame end is always the last result of its pixel
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("end of frame without end of run");

  // no result without an input pixel
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seen_q)
    else $error("result before any input");

endmodule

bind separable_triangle_smoothing_core stc_checker u_stc_checker (.*);

/* tb/smoothing_scoreboard_pkg.sv */
// Scoreboard for the separable triangle smoothing core testbench.
// Predicts results from accepted pixels and register writes, then checks them.
// Depends on stc_pkg for the register codes, the result struct and the size limits.
package smoothing_scoreboard_pkg;
  import stc_pkg::*;

  class smoothing_scoreboard;
    // register copies, as written
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    // scan position and the two previous pixels of the current row
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned px_prev;
    int unsigned px_prev2;
    // horizontal results of rows r-2 and r-1
    logic [PIX_W-1:0] hbuf_older[MAX_WIDTH_DEF];
    logic [PIX_W-1:0] hbuf_newer[MAX_WIDTH_DEF];
    // results still to come, oldest first
    res_t expected_q[$];
    int unsigned errors;
    int unsigned pixels_in;
    int unsigned results_ok;
    int unsigned frames_done;
    int unsigned reg_writes;

    function new();
      width_reg   = 9'd2;
      height_reg  = 9'd2;
      row_pos     = 0;
      col_pos     = 0;
      px_prev     = 0;
      px_prev2    = 0;
      errors      = 0;
      pixels_in   = 0;
      results_ok  = 0;
      frames_done = 0;
      reg_writes  = 0;
    endfunction

    // sizes below 2 act as 2, above the maximum as the maximum
    function int unsigned eff_size(logic [CFG_W-1:0] raw, int unsigned hi);
      if (raw < 2) return 2;
      if (raw > hi) return hi;
      return raw;
    endfunction

    function int unsigned eff_width();
      return eff_size(width_reg, MAX_WIDTH_DEF);
    endfunction

    function int unsigned eff_height();
      return eff_size(height_reg, MAX_HEIGHT_DEF);
    endfunction

    // (768*center + 256*neighbor) >> 10
    function int unsigned edge_mix(int unsigned center, int unsigned nb);
      return (center * 768 + nb * 256) >> 10;
    endfunction

    // (128*a + 768*b + 128*c) >> 10
    function int unsigned mid_mix(int unsigned a, int unsigned b, int unsigned c);
      return (a * 128 + b * 768 + c * 128) >> 10;
    endfunction

    // pixels still needed to close the current frame, with sizes as they stand
    function int unsigned items_left();
      int unsigned w, hgt, c, r;
      w   = eff_width();
      hgt = eff_height();
      c   = (col_pos >= w) ? w - 1 : col_pos;
      r   = (row_pos >= hgt) ? hgt - 1 : row_pos;
      return (hgt - 1 - r) * w + (w - c);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MAP_WIDTH:  width_reg = val;
        CFG_MAP_HEIGHT: height_reg = val;
        default: ;
      endcase
      reg_writes++;
    endfunction

    function void push_result(int unsigned val, int unsigned r, int unsigned c);
      res_t e;
      e.smoothed = val[7:0];
      e.row      = r[7:0];
      e.col      = c[7:0];
      e.eor      = 1'b0;
      e.eof      = 1'b0;
      expected_q.push_back(e);
    endfunction

    // one finished horizontal value: close the row above, and this row on the last row
    function void fold_h(int unsigned h, int unsigned col, int unsigned r, bit last_row);
      int unsigned older, newer, v;
      older = hbuf_older[col];
      newer = hbuf_newer[col];
      if (r >= 1) begin
        v = (r == 1) ? edge_mix(newer, h) : mid_mix(older, newer, h);
        push_result(v, r - 1, col);
        if (last_row) push_result(edge_mix(h, newer), r, col);
      end
      hbuf_older[col] = newer[7:0];
      hbuf_newer[col] = h[7:0];
    endfunction

    // accepted pixel transaction
    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned w, hgt, c, r, h, n0, last_idx;
      bit last_col, last_row;
      w   = eff_width();
      hgt = eff_height();
      if (col_pos >= w) col_pos = w - 1;
      if (row_pos >= hgt) row_pos = hgt - 1;
      c        = col_pos;
      r        = row_pos;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= hgt);
      n0       = expected_q.size();
      pixels_in++;

      if (c >= 1) begin
        h = (c == 1) ? edge_mix(px_prev, px) : mid_mix(px_prev2, px_prev, px);
        fold_h(h, c - 1, r, last_row);
      end
      if (last_col) fold_h(edge_mix(px, px_prev), c, r, last_row);
      px_prev2 = px_prev;
      px_prev  = px;

      // flag the last result of this pixel, and of the frame
      if (expected_q.size() > n0) begin
        last_idx = expected_q.size() - 1;
        expected_q[last_idx].eor = 1'b1;
        if (last_row && last_col) expected_q[last_idx].eof = 1'b1;
      end

      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : r + 1;
        if (last_row) frames_done++;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // accepted result transaction
    function void check_result(res_t got);
      res_t want;
      bit bad;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual row %0d col %0d val %0d",
                 $time, got.row, got.col, got.smoothed);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      bad  = 1'b0;
      bad |= field_differs("smoothed", want.smoothed, got.smoothed);
      bad |= field_differs("out_row", want.row, got.row);
      bad |= field_differs("out_col", want.col, got.col);
      bad |= field_differs("end_of_run", 8'(want.eor), 8'(got.eor));
      bad |= field_differs("end_of_frame", 8'(want.eof), 8'(got.eof));
      if (bad) errors++;
      else results_ok++;
    endfunction
  endclass

endpackage

/* tb/testbench.sv */
// Top-level testbench for separable_triangle_smoothing_core.
// Drives pixel and register transactions, applies output backpressure, checks results.
// Depends on stc_pkg and smoothing_scoreboard_pkg.
module testbench;
  import stc_pkg::*;
  import smoothing_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic [0:0]       m_axis_tuser;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [0:0]       cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  smoothing_scoreboard sb;
  res_t                seen_res;

  // idling chances in percent; receiver settings change only after a rising edge
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;
  int unsigned hold_left;

  typedef enum int {PIX_RANDOM, PIX_ZERO, PIX_FULL, PIX_CHECKER} pix_style_e;

  separable_triangle_smoothing_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // hard stop
  initial begin
    #3_000_000;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: every transaction goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen_res.smoothed = m_axis_tdata[7:0];
        seen_res.row      = m_axis_tdata[15:8];
        seen_res.col      = m_axis_tdata[23:16];
        seen_res.eor      = m_axis_tlast;
        seen_res.eof      = m_axis_tuser[0];
        sb.check_result(seen_res);
      end
    end
  end

  task automatic set_idling(int unsigned snd, int unsigned rcv);
    @(posedge clk_i);
    recv_idle_pct = rcv;
    send_idle_pct = snd;
    @(negedge clk_i);
  endtask

  // valid stays up between back-to-back writes; callers lower it
  task automatic write_cfg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_cfg(CFG_MAP_WIDTH, w);
    write_cfg(CFG_MAP_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_pixels(int unsigned n, pix_style_e style);
    logic [7:0] px;
    for (int unsigned k = 0; k < n; k++) begin
      case (style)
        PIX_ZERO:    px = 8'h00;
        PIX_FULL:    px = 8'hFF;
        PIX_CHECKER: px = (k % 2) ? 8'hFF : 8'h00;
        default:     px = 8'($urandom_range(255));
      endcase
      send_pixel(px);
    end
  endtask

  // wait until every expected result is in, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_dim(int unsigned lo_big, int unsigned hi_big,
                                           int unsigned hi_norm);
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel == 0) return $urandom_range(1);
    if (sel == 1) return $urandom_range(hi_big, lo_big);
    return $urandom_range(hi_norm, 2);
  endfunction

  // one random frame, now and then cut short by a mid-frame size reduction
  task automatic random_frame(output int unsigned sent);
    int unsigned w, h, ew, eh, k;
    pix_style_e style;
    w     = pick_dim(11, 16, 10);
    h     = pick_dim(7, 8, 6);
    ew    = (w < 2) ? 2 : w;
    eh    = (h < 2) ? 2 : h;
    style = ($urandom_range(7) < 6) ? PIX_RANDOM : pix_style_e'($urandom_range(3, 1));
    sent  = 0;
    set_size(CFG_W'(w), CFG_W'(h));
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(sb.items_left() - 1, 1);
      send_pixels(k, style);
      sent += k;
      drain();
      set_size(CFG_W'($urandom_range(ew, 2)), CFG_W'($urandom_range(eh, 2)));
    end
    k = sb.items_left();
    send_pixels(k, style);
    sent += k;
    drain();
  endtask

  initial begin
    int unsigned phase_items, sent;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MAP_WIDTH;
    cfg_data_i    = '0;
    send_idle_pct = 12;
    recv_idle_pct = 48;
    hold_request  = 1'b0;
    hold_left     = 0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: reset sizes, clamped register values, mid-frame size cut
    send_pixels(4, PIX_CHECKER);
    drain();
    set_size(9'd1, 9'd0);
    send_pixels(4, PIX_FULL);
    drain();
    set_size(9'd5, 9'd4);
    send_pixels(13, PIX_RANDOM);
    drain();
    set_size(9'd3, 9'd2);
    send_pixels(sb.items_left(), PIX_ZERO);
    drain();

    // over-range width acts as 256: one full-width row, then the frame is cut to width 2
    set_size(9'd511, 9'd2);
    send_pixels(256, PIX_RANDOM);
    drain();
    set_size(9'd2, 9'd2);
    send_pixels(sb.items_left(), PIX_RANDOM);
    drain();
    // over-range height acts as 256; the frame is cut after a few rows
    set_size(9'd2, 9'd511);
    send_pixels(10, PIX_RANDOM);
    drain();
    set_size(9'd2, 9'd6);
    send_pixels(sb.items_left(), PIX_RANDOM);
    drain();

    // random frames in three idling phases
    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       set_idling(12, 48);
        1:       set_idling(48, 12);
        default: set_idling(0, 0);
      endcase
      phase_items = 0;
      if (p == 2) begin
        // long output hold-off so the core backs up into its input
        @(posedge clk_i);
        hold_request = 1'b1;
        @(negedge clk_i);
        set_size(9'd8, 9'd6);
        send_pixels(48, PIX_RANDOM);
        drain();
        phase_items += 48;
      end
      while (phase_items < 25 + ((p == 2) ? 48 : 0)) begin
        random_frame(sent);
        phase_items += sent;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run: %0d pixels, %0d results matched, %0d frames, %0d register writes",
             sb.pixels_in, sb.results_ok, sb.frames_done, sb.reg_writes);
    $display("small random maps, a 256-wide row, clamped and cut frames, long output stall");
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
